FILE: hdl/pcc_pkg.sv
// Shared types and constants of the pairwise column chi-square block.
// Holds the controller command and status structs and the state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

   localparam int CHI_W       = 42;
   localparam int COL_W       = 3;
   localparam int SYM_W       = 4;
   localparam int NUM_SYM     = 8;
   localparam int LEV_W       = 5;
   localparam int LPROD_W     = 2 * LEV_W;
   localparam int DSUM_W      = 7;
   localparam int REQ_DATA_W  = NUM_SYM * SYM_W;
   localparam int RSP_DATA_W  = 136;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int COUNT_W     = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEVELS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 2'd1;

   localparam logic [CSR_DATA_W-1:0] LEVELS_RESET  = 32'h1111_1111;
   localparam logic [COUNT_W-1:0]    COLUMNS_RESET = 4'd8;

   localparam logic KIND_PAIR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [CHI_W-1:0] CHI_MAX = {CHI_W{1'b1}};

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_NEXT,
      ST_SWEEP,
      ST_DRAIN,
      ST_MULT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH,
      ST_EMIT,
      ST_SUMMARY,
      ST_SUM_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic write_row;
      logic clear_wr;
      logic sweep_rd;
      logic start_stats;
      logic start_pair;
      logic mult;
      logic div_start;
      logic finish_pair;
      logic load_summary;
      logic reset_design;
   } cmd_type;

   typedef struct packed {
      logic                pipe_busy;
      logic                div_busy;
      logic [COUNT_W-1:0]  used_cols;
   } status_type;

endpackage
`default_nettype wire

FILE: hdl/pcc_divider.sv
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for the chi-square scaling; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module pcc_divider #(
   parameter int DW = 52,
   parameter int RW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [RW-1:0] divisor,
   output logic               busy,
   output logic [DW-1:0]      quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     q_ff, q_in;
   logic [RW-1:0]     d_ff, d_in;
   logic [RW:0]       rem_sh;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      rem_sh  = {rem_ff, q_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW);
         rem_in  = '0;
         q_in    = dividend;
         d_in    = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, d_ff}) begin
            rem_in = RW'(rem_sh - {1'b0, d_ff});
            q_in   = {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[RW-1:0];
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

FILE: hdl/pcc_datapath.sv
// Datapath: configuration registers, one histogram memory per column pair,
// the sweep accumulator, multiplier, divider and result registers.
// Depends on pcc_pkg and pcc_divider.
`timescale 1ns / 1ps
`default_nettype none
module pcc_datapath
   import pcc_pkg::*;
#(
   parameter int MAX_COLUMNS = 8,
   parameter int MAX_LEVELS  = 16,
   parameter int MAX_ROWS    = 4096,
   parameter int FRAC_BITS   = 16,
   parameter int AW          = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [COL_W-1:0]       col_i,
   input  wire logic [COL_W-1:0]       col_j,
   input  wire logic [AW-1:0]          mem_addr,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int NP    = MAX_COLUMNS * (MAX_COLUMNS - 1) / 2;
   localparam int LW    = AW / 2;
   localparam int DEPTH = 2 ** AW;
   localparam int CW    = $clog2(MAX_ROWS + 1);
   localparam int SW    = 2 * CW;
   localparam int NUMW  = SW + LPROD_W;
   localparam int DW    = NUMW + FRAC_BITS;
   localparam int EW    = (DW > CHI_W) ? DW : CHI_W + 1;
   localparam int CMPW  = (CW > DSUM_W) ? CW : DSUM_W;

   function automatic int pair_col(input int p, input bit second);
      int n;
      int res;
      n   = 0;
      res = 0;
      for (int a = 0; a < MAX_COLUMNS; a++) begin
         for (int b = a + 1; b < MAX_COLUMNS; b++) begin
            if (n == p) begin
               res = second ? b : a;
            end
            n++;
         end
      end
      return res;
   endfunction

   logic [CSR_DATA_W-1:0] levels_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    used;
   logic [LEV_W-1:0]      lev [NUM_SYM];
   logic [NUM_SYM-1:0]    ok_in;

   logic [CW-1:0]         rows_ff;
   logic                  err_ff;
   logic                  full;
   logic [REQ_DATA_W-1:0] sym_ff;

   logic [CW-1:0]         rd_bank_ff [NP];
   logic [NP-1:0]         en_ff;
   logic [NP-1:0]         bank_hit;
   logic [CW-1:0]         rd_sel;

   logic [LEV_W-1:0]      li, lj;
   logic                  mask;
   logic                  sv1_ff, mk1_ff, sv2_ff;
   logic [SW-1:0]         sq_ff;
   logic [SW-1:0]         acc_ff;
   logic [LPROD_W-1:0]    lprod_ff;
   logic [NUMW-1:0]       num_ff;
   logic                  div_busy;
   logic [DW-1:0]         quotient;

   logic [EW-1:0]         q_ext;
   logic [CHI_W-1:0]      v42, sub, chi;
   logic [CHI_W:0]        total_sum;
   logic [CHI_W-1:0]      total_ff, min_ff, max_ff;
   logic [DSUM_W-1:0]     dsum;
   logic                  sup;

   logic                  kind_ff, last_ff, sup_ff, rerr_ff;
   logic [COL_W-1:0]      ci_ff, cj_ff;
   logic [CHI_W-1:0]      o_chi_ff, o_min_ff, o_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
         count_ff  <= COLUMNS_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_LEVELS) begin
            levels_ff <= csr_data;
         end else if (csr_index == CSR_COLUMNS) begin
            count_ff <= csr_data[COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      used = count_ff;
      if (count_ff < COUNT_W'(2)) begin
         used = COUNT_W'(2);
      end else if (count_ff > COUNT_W'(MAX_COLUMNS)) begin
         used = COUNT_W'(MAX_COLUMNS);
      end
   end

   always_comb begin
      logic [LEV_W-1:0] l;
      dsum = '0;
      for (int k = 0; k < NUM_SYM; k++) begin
         l = {1'b0, levels_ff[SYM_W*k +: SYM_W]} + LEV_W'(1);
         lev[k]   = (l > LEV_W'(MAX_LEVELS)) ? LEV_W'(MAX_LEVELS) : l;
         ok_in[k] = {1'b0, req_tdata[SYM_W*k +: SYM_W]} < lev[k];
         if (COUNT_W'(k) < used) begin
            dsum = dsum + DSUM_W'(lev[k] - LEV_W'(1));
         end
      end
   end

   assign full = (rows_ff == CW'(MAX_ROWS));

   always_ff @(posedge clock) begin
      if (reset || cmd.reset_design) begin
         rows_ff <= '0;
         err_ff  <= 1'b0;
      end else if (cmd.accept && !full) begin
         rows_ff <= rows_ff + CW'(1);
         for (int k = 0; k < NUM_SYM; k++) begin
            if (COUNT_W'(k) < used && !ok_in[k]) begin
               err_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sym_ff <= req_tdata;
      end
   end

   for (genvar b = 0; b < NP; b++) begin : g_bank
      localparam int PI = pair_col(b, 1'b0);
      localparam int PJ = pair_col(b, 1'b1);

      logic [CW-1:0] mem [DEPTH];
      logic [AW-1:0] ra, wa;
      logic          we;

      assign ra = cmd.sweep_rd ? mem_addr
                : {req_tdata[SYM_W*PI +: LW], req_tdata[SYM_W*PJ +: LW]};
      assign wa = cmd.clear_wr ? mem_addr
                : {sym_ff[SYM_W*PI +: LW], sym_ff[SYM_W*PJ +: LW]};
      assign we = cmd.clear_wr || (cmd.write_row && en_ff[b]);
      assign bank_hit[b] = (col_i == COL_W'(PI)) && (col_j == COL_W'(PJ));

      always_ff @(posedge clock) begin
         if (we) begin
            mem[wa] <= cmd.clear_wr ? '0 : rd_bank_ff[b] + CW'(1);
         end
         rd_bank_ff[b] <= mem[ra];
      end

      always_ff @(posedge clock) begin
         if (cmd.accept) begin
            en_ff[b] <= (COUNT_W'(PJ) < used) && ok_in[PI] && ok_in[PJ] && !full;
         end
      end
   end

   always_comb begin
      rd_sel = '0;
      for (int b = 0; b < NP; b++) begin
         if (bank_hit[b]) begin
            rd_sel = rd_sel | rd_bank_ff[b];
         end
      end
   end

   assign li   = lev[col_i];
   assign lj   = lev[col_j];
   assign mask = (LEV_W'(mem_addr[AW-1:LW]) < li) && (LEV_W'(mem_addr[LW-1:0]) < lj);

   always_ff @(posedge clock) begin
      if (reset) begin
         sv1_ff <= 1'b0;
         sv2_ff <= 1'b0;
      end else begin
         sv1_ff <= cmd.sweep_rd;
         sv2_ff <= sv1_ff;
      end
      mk1_ff   <= mask;
      sq_ff    <= mk1_ff ? SW'(rd_sel) * SW'(rd_sel) : '0;
      lprod_ff <= LPROD_W'(li) * LPROD_W'(lj);
      if (cmd.start_pair) begin
         acc_ff <= '0;
      end else if (sv2_ff) begin
         acc_ff <= acc_ff + sq_ff;
      end
      if (cmd.mult) begin
         num_ff <= NUMW'(lprod_ff) * NUMW'(acc_ff);
      end
   end

   pcc_divider #(
      .DW(DW),
      .RW(CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({num_ff, {FRAC_BITS{1'b0}}}),
      .divisor  (rows_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      q_ext = EW'(quotient);
      v42   = q_ext[CHI_W-1:0];
      sub   = CHI_W'(rows_ff) << FRAC_BITS;
      if (|q_ext[EW-1:CHI_W]) begin
         chi = CHI_MAX;
      end else if (v42 <= sub) begin
         chi = '0;
      end else begin
         chi = v42 - sub;
      end
      total_sum = {1'b0, total_ff} + {1'b0, chi};
      sup = (rows_ff != '0) && (CMPW'(dsum) >= CMPW'(rows_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.start_stats) begin
         total_ff <= '0;
         min_ff   <= CHI_MAX;
         max_ff   <= '0;
      end else if (cmd.finish_pair) begin
         total_ff <= total_sum[CHI_W] ? CHI_MAX : total_sum[CHI_W-1:0];
         if (chi < min_ff) begin
            min_ff <= chi;
         end
         if (chi > max_ff) begin
            max_ff <= chi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_pair) begin
         kind_ff  <= KIND_PAIR;
         last_ff  <= 1'b0;
         ci_ff    <= col_i;
         cj_ff    <= col_j;
         o_chi_ff <= chi;
         o_min_ff <= '0;
         o_max_ff <= '0;
         sup_ff   <= 1'b0;
         rerr_ff  <= 1'b0;
      end else if (cmd.load_summary) begin
         kind_ff  <= KIND_SUMMARY;
         last_ff  <= 1'b1;
         ci_ff    <= '0;
         cj_ff    <= '0;
         o_chi_ff <= total_ff;
         o_min_ff <= min_ff;
         o_max_ff <= max_ff;
         sup_ff   <= sup;
         rerr_ff  <= err_ff;
      end
   end

   assign rsp_tdata = {2'b00, rerr_ff, sup_ff, o_max_ff, o_min_ff, o_chi_ff, cj_ff, ci_ff};
   assign rsp_tuser = kind_ff;
   assign rsp_tlast = last_ff;

   assign status.pipe_busy = sv1_ff || sv2_ff;
   assign status.div_busy  = div_busy;
   assign status.used_cols = used;

endmodule
`default_nettype wire

FILE: hdl/pcc_controller.sv
// Controller state machine: row loading, per-pair sweep and division,
// result hand-off and the histogram clearing pass. Depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcc_controller
   import pcc_pkg::*;
#(
   parameter int MAX_COLUMNS = 8,
   parameter int AW          = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic             req_tlast,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic                  csr_ready,
   output cmd_type               cmd,
   input  wire status_type       status,
   output logic [COL_W-1:0]      col_i,
   output logic [COL_W-1:0]      col_j,
   output logic [AW-1:0]         mem_addr
);

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
   localparam logic [COL_W-1:0] COL_PEN  = COL_W'(MAX_COLUMNS - 2);
   localparam logic [AW-1:0]    ADDR_END = {AW{1'b1}};

   state_type         state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [COL_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic              last_ff, last_in;
   logic              valid_ff, valid_in;
   logic              at_end;

   assign at_end = (i_ff == COL_PEN) && (j_ff == COL_LAST);

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      cmd      = '0;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == ADDR_END) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = !req_tvalid;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               last_in  = req_tlast;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_row = 1'b1;
            if (last_ff) begin
               cmd.start_stats = 1'b1;
               i_in     = '0;
               j_in     = COL_W'(1);
               state_in = ST_NEXT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NEXT: begin
            if (COUNT_W'(j_ff) < status.used_cols) begin
               cmd.start_pair = 1'b1;
               addr_in  = '0;
               state_in = ST_SWEEP;
            end else if (at_end) begin
               state_in = ST_SUMMARY;
            end else if (j_ff == COL_LAST) begin
               i_in = i_ff + COL_W'(1);
               j_in = i_ff + COL_W'(2);
            end else begin
               j_in = j_ff + COL_W'(1);
            end
         end
         ST_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == ADDR_END) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish_pair = 1'b1;
            valid_in = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               if (at_end) begin
                  state_in = ST_SUMMARY;
               end else begin
                  state_in = ST_NEXT;
                  if (j_ff == COL_LAST) begin
                     i_in = i_ff + COL_W'(1);
                     j_in = i_ff + COL_W'(2);
                  end else begin
                     j_in = j_ff + COL_W'(1);
                  end
               end
            end
         end
         ST_SUMMARY: begin
            cmd.load_summary = 1'b1;
            valid_in = 1'b1;
            state_in = ST_SUM_EMIT;
         end
         ST_SUM_EMIT: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               cmd.reset_design = 1'b1;
               addr_in  = '0;
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign col_i      = i_ff;
   assign col_j      = j_ff;
   assign mem_addr   = addr_ff;

endmodule
`default_nettype wire

FILE: hdl/pairwise_column_chi_square.sv
// Pairwise column chi-square uniformity block, top level.
// Joins pcc_controller and pcc_datapath; depends on pcc_pkg.
// Each row word is handled as a histogram read, then an increment write.
// On the last row, each pair in use is swept over its 2^(2*log2(MAX_LEVELS))
// cells, 256 by default, at one cell per cycle; the read pipeline then
// drains, and the sum is multiplied and passed to a divider of one quotient
// bit per cycle; its result word then waits for rsp_tready. After the summary
// word all histogram cells, 256 by default, are cleared, as after reset,
// and no row word is taken during that pass. Configuration words are taken
// only while the block waits for a row word and none is offered.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_column_chi_square
   import pcc_pkg::*;
#(
   parameter int MAX_COLUMNS = 8,
   parameter int MAX_LEVELS  = 16,
   parameter int MAX_ROWS    = 4096,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // symbol_0 .. symbol_7, 4 bits each from the lowest bit up
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic                   req_tlast,
   // col_first, col_second, chi_value, chi_low, chi_high,
   // super_saturated, range_error, then two zero bits
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // result_kind
   output logic                        rsp_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tlast,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = 2 * $clog2(MAX_LEVELS);

   cmd_type           cmd;
   status_type        status;
   logic [COL_W-1:0]  col_i, col_j;
   logic [AW-1:0]     mem_addr;

   pcc_controller #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .AW(AW)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_ready  (csr_ready),
      .cmd        (cmd),
      .status     (status),
      .col_i      (col_i),
      .col_j      (col_j),
      .mem_addr   (mem_addr)
   );

   pcc_datapath #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_LEVELS (MAX_LEVELS),
      .MAX_ROWS   (MAX_ROWS),
      .FRAC_BITS  (FRAC_BITS),
      .AW         (AW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .col_i     (col_i),
      .col_j     (col_j),
      .mem_addr  (mem_addr),
      .req_tdata (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
`default_nettype wire
